// File: sv/bpc_pkg.sv
// Shared types, constants and status codes for the barometric pressure compensation block.
// Used by every module of the block; depends on nothing.
package bpc_pkg;

   localparam int unsigned PRESSURE_FRACTION_BITS = 8;
   localparam int unsigned PRESS_SHR = (PRESSURE_FRACTION_BITS <= 8) ?
                                       (8 - PRESSURE_FRACTION_BITS) : 0;
   localparam int unsigned PRESS_SHL = (PRESSURE_FRACTION_BITS > 8) ?
                                       (PRESSURE_FRACTION_BITS - 8) : 0;

   localparam int unsigned DIV_STEPS = 64;

   localparam logic [19:0] SKIPPED_RAW = 20'h80000;

   localparam logic signed [14:0] TEMP_MIN_CENTI = -15'sd4000;
   localparam logic signed [14:0] TEMP_MAX_CENTI = 15'sd8500;

   localparam logic signed [63:0] MIN_PRESSURE_Q8 = 64'sd7680000;
   localparam logic signed [63:0] MAX_PRESSURE_Q8 = 64'sd30720000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SKIPPED  = 2'd1;
   localparam logic [1:0] ST_ZERO_DIV = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   localparam logic [1:0] CSR_TEMP_CAL = 2'd0;
   localparam logic [1:0] CSR_PRES_A   = 2'd1;
   localparam logic [1:0] CSR_PRES_B   = 2'd2;
   localparam logic [1:0] CSR_PRES_C   = 2'd3;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
   } bpc_req_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [24:0]        pressure_q8;
      logic [1:0]         status;
   } bpc_rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } bpc_calib_type;

   typedef struct packed {
      logic signed [14:0] temp;
      logic [1:0]         status;
   } bpc_meta_type;

   typedef struct packed {
      logic [63:0]  ma;
      logic [30:0]  mb;
      logic         qneg;
      bpc_meta_type meta;
   } bpc_div_type;

endpackage

// File: sv/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block: calibration registers and pipeline.
// Depends on bpc_pkg, bpc_front, bpc_div and bpc_back.
//
//   channel   ports                              handshake
//   -------   --------------------------------   ------------------------------
//   request   start, busy, req_data              taken when start=1 and busy=0
//   result    rsp_valid, rsp_data                one-cycle strobe, no back-pressure
//   config    csr_write, csr_index, csr_data     written when csr_write=1
//
// The datapath is one pipeline of 82 register stages: 11 in the front (temperature
// polynomial and pressure coefficients), 65 in the divider (one quotient bit per stage
// plus sign correction) and 6 in the back. A request passes through the front, the
// divider and the back in that order, and its result then shows on rsp_data with
// rsp_valid high. busy is never raised: a new request may be taken at every edge, and
// results leave in the order their requests came in. Since the receiver cannot stall,
// the pipeline never holds. Reset clears the valid bits and the calibration registers;
// payload stages keep whatever they held. Calibration must be written only while no
// request is in flight; the block itself does not enforce it.
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bpc_req_type req_data,
   output logic        rsp_valid,
   output bpc_rsp_type rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0] temp_cal_ff, pres_a_ff, pres_b_ff, pres_c_ff;
   bpc_calib_type cal;

   logic         front_valid;
   bpc_div_type  front_div;
   logic         div_valid;
   logic signed [63:0] div_quot;
   bpc_meta_type div_meta;

   // Calibration registers, one per index.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         pres_a_ff   <= '0;
         pres_b_ff   <= '0;
         pres_c_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TEMP_CAL: temp_cal_ff <= csr_data;
            CSR_PRES_A:   pres_a_ff   <= csr_data;
            CSR_PRES_B:   pres_b_ff   <= csr_data;
            CSR_PRES_C:   pres_c_ff   <= csr_data;
            default:      temp_cal_ff <= temp_cal_ff;
         endcase
      end
   end

   // Unpack the twelve factory words.
   always_comb begin
      cal.t1 = temp_cal_ff[15:0];
      cal.t2 = temp_cal_ff[31:16];
      cal.t3 = temp_cal_ff[47:32];
      cal.p1 = pres_a_ff[15:0];
      cal.p2 = pres_a_ff[31:16];
      cal.p3 = pres_a_ff[47:32];
      cal.p4 = pres_b_ff[15:0];
      cal.p5 = pres_b_ff[31:16];
      cal.p6 = pres_b_ff[47:32];
      cal.p7 = pres_c_ff[15:0];
      cal.p8 = pres_c_ff[31:16];
      cal.p9 = pres_c_ff[47:32];
   end

   // The pipeline takes a request every cycle.
   assign busy = 1'b0;

   bpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_data   (req_data),
      .cal       (cal),
      .out_valid (front_valid),
      .out_div   (front_div)
   );

   bpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_div    (front_div),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_meta  (div_meta)
   );

   bpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_quot   (div_quot),
      .in_meta   (div_meta),
      .cal       (cal),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

// File: sv/bpc_front.sv
// Front pipeline: temperature polynomial, pressure coefficients and division operands.
// Depends on bpc_pkg.
module bpc_front
   import bpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  bpc_req_type   in_data,
   input  bpc_calib_type cal,
   output logic          out_valid,
   output bpc_div_type   out_div
);

   logic [10:0] valid_ff, valid_in;

   // Stage 0: captured request.
   logic [19:0] rp0_ff, rt0_ff;
   logic        skip0_ff;

   // Stage 1.
   logic signed [18:0] d1;
   logic signed [17:0] d2;
   logic signed [34:0] prod1_ff, prod1_in;
   logic signed [35:0] sq1_ff, sq1_in;
   logic [19:0] rp1_ff;
   logic        skip1_ff;

   // Stage 2.
   logic signed [35:0] sqsh;
   logic signed [34:0] v1t2_ff, v1t2_in;
   logic signed [51:0] v2a2_ff, v2a2_in;
   logic [19:0] rp2_ff;
   logic        skip2_ff;

   // Stage 3.
   logic signed [31:0] tf3_ff, tf3_in;
   logic [19:0] rp3_ff;
   logic        skip3_ff;

   // Stage 4.
   logic signed [31:0] vp;
   logic signed [35:0] tcw;
   logic signed [14:0] tsat;
   logic signed [63:0] sqv4_ff, sqv4_in;
   logic signed [47:0] m5_4_ff, m5_4_in, m2_4_ff, m2_4_in;
   logic [19:0] rp4_ff;
   bpc_meta_type meta4_ff, meta4_in;

   // Stage 5.
   logic signed [79:0] a2w, a1w;
   logic signed [63:0] a2_5_ff, a1_5_ff;
   logic signed [47:0] m5_5_ff, m2_5_ff;
   logic [19:0] rp5_ff;
   bpc_meta_type meta5_ff;

   // Stage 6.
   logic signed [63:0] v2_6_ff, v2_6_in, v1_6_ff, v1_6_in;
   logic [19:0] rp6_ff;
   bpc_meta_type meta6_ff;

   // Stage 7.
   logic [63:0] x7;
   logic [79:0] dw;
   logic [63:0] d7_ff;
   logic signed [63:0] v2_7_ff;
   logic [19:0] rp7_ff;
   bpc_meta_type meta7_ff;

   // Stage 8.
   logic [20:0] pp;
   logic [63:0] num8_ff, num8_in;
   logic signed [30:0] div8_ff;
   bpc_meta_type meta8_ff, meta8_in;

   // Stage 9.
   logic [75:0] nw;
   logic [63:0] num9_ff;
   logic [30:0] mb9_ff, mb9_in;
   logic        dneg9_ff;
   bpc_meta_type meta9_ff;

   // Stage 10.
   bpc_div_type div10_ff, div10_in;

   assign valid_in = {valid_ff[9:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      d1       = $signed({2'b0, rt0_ff[19:3]}) - $signed({2'b0, cal.t1, 1'b0});
      d2       = $signed({2'b0, rt0_ff[19:4]}) - $signed({2'b0, cal.t1});
      prod1_in = d1 * cal.t2;
      sq1_in   = d2 * d2;

      sqsh    = sq1_ff >>> 12;
      v1t2_in = prod1_ff >>> 11;
      v2a2_in = sqsh * cal.t3;

      tf3_in = 32'(v1t2_ff) + 32'(v2a2_ff >>> 14);

      vp      = tf3_ff - 32'sd128000;
      sqv4_in = vp * vp;
      m5_4_in = vp * cal.p5;
      m2_4_in = vp * cal.p2;
      tcw     = ((36'(tf3_ff) * 36'sd5) + 36'sd128) >>> 8;
      if (tcw < TEMP_MIN_CENTI) begin
         tsat = TEMP_MIN_CENTI;
      end else if (tcw > TEMP_MAX_CENTI) begin
         tsat = TEMP_MAX_CENTI;
      end else begin
         tsat = 15'(tcw);
      end
      meta4_in.temp   = skip3_ff ? 15'sd0 : tsat;
      meta4_in.status = skip3_ff ? ST_SKIPPED : ST_OK;

      a2w = sqv4_ff * cal.p6;
      a1w = sqv4_ff * cal.p3;

      v2_6_in = a2_5_ff + (64'(m5_5_ff) <<< 17) + (64'(cal.p4) <<< 35);
      v1_6_in = (a1_5_ff >>> 8) + (64'(m2_5_ff) <<< 12);

      x7 = 64'h0000_8000_0000_0000 + v1_6_ff;
      dw = x7 * cal.p1;

      pp      = 21'h100000 - {1'b0, rp7_ff};
      num8_in = {12'b0, pp, 31'b0} - v2_7_ff;
      meta8_in = meta7_ff;
      if (meta7_ff.status == ST_OK && d7_ff[63:33] == 31'd0) begin
         meta8_in.status = ST_ZERO_DIV;
      end

      nw     = num8_ff * 12'd3125;
      mb9_in = div8_ff[30] ? 31'(-div8_ff) : 31'(div8_ff);

      div10_in.ma   = num9_ff[63] ? (64'd0 - num9_ff) : num9_ff;
      div10_in.mb   = mb9_ff;
      div10_in.qneg = num9_ff[63] ^ dneg9_ff;
      div10_in.meta = meta9_ff;
   end

   always_ff @(posedge clock) begin
      rp0_ff   <= in_data.raw_pressure;
      rt0_ff   <= in_data.raw_temperature;
      skip0_ff <= (in_data.raw_pressure == SKIPPED_RAW) ||
                  (in_data.raw_temperature == SKIPPED_RAW);

      prod1_ff <= prod1_in;
      sq1_ff   <= sq1_in;
      rp1_ff   <= rp0_ff;
      skip1_ff <= skip0_ff;

      v1t2_ff  <= v1t2_in;
      v2a2_ff  <= v2a2_in;
      rp2_ff   <= rp1_ff;
      skip2_ff <= skip1_ff;

      tf3_ff   <= tf3_in;
      rp3_ff   <= rp2_ff;
      skip3_ff <= skip2_ff;

      sqv4_ff  <= sqv4_in;
      m5_4_ff  <= m5_4_in;
      m2_4_ff  <= m2_4_in;
      rp4_ff   <= rp3_ff;
      meta4_ff <= meta4_in;

      a2_5_ff  <= a2w[63:0];
      a1_5_ff  <= a1w[63:0];
      m5_5_ff  <= m5_4_ff;
      m2_5_ff  <= m2_4_ff;
      rp5_ff   <= rp4_ff;
      meta5_ff <= meta4_ff;

      v2_6_ff  <= v2_6_in;
      v1_6_ff  <= v1_6_in;
      rp6_ff   <= rp5_ff;
      meta6_ff <= meta5_ff;

      d7_ff    <= dw[63:0];
      v2_7_ff  <= v2_6_ff;
      rp7_ff   <= rp6_ff;
      meta7_ff <= meta6_ff;

      num8_ff  <= num8_in;
      div8_ff  <= d7_ff[63:33];
      meta8_ff <= meta8_in;

      num9_ff  <= nw[63:0];
      mb9_ff   <= mb9_in;
      dneg9_ff <= div8_ff[30];
      meta9_ff <= meta8_ff;

      div10_ff <= div10_in;
   end

   assign out_valid = valid_ff[10];
   assign out_div   = div10_ff;

endmodule

// File: sv/bpc_div.sv
// Pipelined restoring divider: one quotient bit per stage, then sign correction.
// Depends on bpc_pkg.
module bpc_div
   import bpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  bpc_div_type        in_div,
   output logic               out_valid,
   output logic signed [63:0] out_quot,
   output bpc_meta_type       out_meta
);

   logic [DIV_STEPS:0] valid_ff;
   logic [63:0]  dvd_ff  [0:DIV_STEPS];
   logic [30:0]  rem_ff  [0:DIV_STEPS];
   logic [30:0]  mb_ff   [0:DIV_STEPS];
   logic         qneg_ff [0:DIV_STEPS];
   bpc_meta_type meta_ff [0:DIV_STEPS];

   logic               valid_out_ff;
   logic signed [63:0] quot_ff;
   bpc_meta_type       meta_out_ff;

   // Entry of the divider is the front's output register.
   assign valid_ff[0] = in_valid;
   assign dvd_ff[0]   = in_div.ma;
   assign rem_ff[0]   = 31'd0;
   assign mb_ff[0]    = in_div.mb;
   assign qneg_ff[0]  = in_div.qneg;
   assign meta_ff[0]  = in_div.meta;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [31:0] trial;
      logic        ge;
      logic [30:0] rem_in;

      always_comb begin
         trial  = {rem_ff[i], dvd_ff[i][63]};
         ge     = trial >= {1'b0, mb_ff[i]};
         rem_in = ge ? 31'(trial - {1'b0, mb_ff[i]}) : trial[30:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         dvd_ff[i+1]  <= {dvd_ff[i][62:0], ge};
         rem_ff[i+1]  <= rem_in;
         mb_ff[i+1]   <= mb_ff[i];
         qneg_ff[i+1] <= qneg_ff[i];
         meta_ff[i+1] <= meta_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else begin
         valid_out_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= qneg_ff[DIV_STEPS] ? $signed(64'd0 - dvd_ff[DIV_STEPS])
                                        : $signed(dvd_ff[DIV_STEPS]);
      meta_out_ff <= meta_ff[DIV_STEPS];
   end

   assign out_valid = valid_out_ff;
   assign out_quot  = quot_ff;
   assign out_meta  = meta_out_ff;

endmodule

// File: sv/bpc_back.sv
// Back pipeline: pressure correction after the division, range check and result register.
// Depends on bpc_pkg.
module bpc_back
   import bpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [63:0] in_quot,
   input  bpc_meta_type       in_meta,
   input  bpc_calib_type      cal,
   output logic               out_valid,
   output bpc_rsp_type        out_rsp
);

   logic [5:0] valid_ff, valid_in;

   // Stage 1: square of p/8192 split into 32-bit halves, and the P8 term.
   logic signed [63:0] a;
   logic [63:0] alal_in, ahal_w;
   logic signed [79:0] m8w;
   logic [63:0] alal1_ff;
   logic [30:0] ahal1_ff;
   logic signed [63:0] m8_1_ff, p1_ff;
   bpc_meta_type meta1_ff;

   // Stage 2.
   logic signed [63:0] sq2_ff, vb2_ff, p2_ff;
   bpc_meta_type meta2_ff;

   // Stage 3.
   logic signed [79:0] tw;
   logic signed [63:0] t3_ff, vb3_ff, p3_ff;
   bpc_meta_type meta3_ff;

   // Stage 4.
   logic signed [63:0] s4_ff;
   bpc_meta_type meta4_ff;

   // Stage 5.
   logic signed [63:0] p5_ff;
   bpc_meta_type meta5_ff;

   // Stage 6: result.
   logic [1:0]  status_fin;
   logic [63:0] pshift;
   bpc_rsp_type rsp_ff, rsp_in;

   assign valid_in = {valid_ff[4:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      a       = in_quot >>> 13;
      alal_in = a[31:0] * a[31:0];
      ahal_w  = a[63:32] * a[31:0];
      m8w     = in_quot * cal.p8;
      tw      = sq2_ff * cal.p9;

      if (meta5_ff.status != ST_OK) begin
         status_fin = meta5_ff.status;
      end else if (p5_ff < MIN_PRESSURE_Q8 || p5_ff > MAX_PRESSURE_Q8) begin
         status_fin = ST_RANGE;
      end else begin
         status_fin = ST_OK;
      end
      pshift = ($unsigned(p5_ff) >> PRESS_SHR) << PRESS_SHL;

      rsp_in.temperature_centi = meta5_ff.temp;
      rsp_in.status            = status_fin;
      rsp_in.pressure_q8       = (status_fin == ST_OK) ? pshift[24:0] : 25'd0;
   end

   always_ff @(posedge clock) begin
      alal1_ff <= alal_in;
      ahal1_ff <= ahal_w[30:0];
      m8_1_ff  <= m8w[63:0];
      p1_ff    <= in_quot;
      meta1_ff <= in_meta;

      // Cross term 2*ah*al lands in the upper word only.
      sq2_ff   <= $signed(alal1_ff + {ahal1_ff, 33'b0});
      vb2_ff   <= m8_1_ff >>> 19;
      p2_ff    <= p1_ff;
      meta2_ff <= meta1_ff;

      t3_ff    <= tw[63:0];
      vb3_ff   <= vb2_ff;
      p3_ff    <= p2_ff;
      meta3_ff <= meta2_ff;

      s4_ff    <= p3_ff + (t3_ff >>> 25) + vb3_ff;
      meta4_ff <= meta3_ff;

      p5_ff    <= (s4_ff >>> 8) + (64'(cal.p7) <<< 4);
      meta5_ff <= meta4_ff;

      rsp_ff   <= rsp_in;
   end

   assign out_valid = valid_ff[5];
   assign out_rsp   = rsp_ff;

`ifndef SYNTH
   a_zero_when_bad: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_rsp.status != ST_OK |-> out_rsp.pressure_q8 == 25'd0)
      else $error("pressure not cleared on a failing status");

   a_skip_temp: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_rsp.status == ST_SKIPPED |-> out_rsp.temperature_centi == 15'sd0)
      else $error("temperature not cleared on a skipped reading");

   a_temp_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_rsp.temperature_centi >= TEMP_MIN_CENTI &&
                    out_rsp.temperature_centi <= TEMP_MAX_CENTI)
      else $error("temperature outside the saturation window");
`endif

endmodule
